// ----- design/sie_pkg.sv -----
// Shared constants, types and helpers of the scoreboard issue/execute core.
// No dependencies; imported by every module of the block.
package sie_pkg;

    localparam int MEM_WORDS     = 4096;
    localparam int NUM_REGISTERS = 16;
    localparam int PROG_DEPTH    = 8192;

    localparam int MEM_AW  = $clog2(MEM_WORDS);
    localparam int REG_W   = 4;
    localparam int XLEN    = 64;
    localparam int CYC_W   = 21;
    localparam int OCYC_W  = 20;
    localparam int PC_W    = 14;
    localparam int TGT_W   = 13;
    localparam int LAT_W   = 4;
    localparam int CFG_W   = 20;
    localparam int CFG_IW  = 3;

    // instruction codes
    localparam logic [3:0] F_ADD  = 4'd0;
    localparam logic [3:0] F_SUB  = 4'd1;
    localparam logic [3:0] F_MUL  = 4'd2;
    localparam logic [3:0] F_MAC  = 4'd3;
    localparam logic [3:0] F_ADDI = 4'd4;
    localparam logic [3:0] F_LD   = 4'd5;
    localparam logic [3:0] F_ST   = 4'd6;
    localparam logic [3:0] F_NOP  = 4'd7;
    localparam logic [3:0] F_HALT = 4'd8;
    localparam logic [3:0] F_BEQ  = 4'd9;
    localparam logic [3:0] F_BNE  = 4'd10;
    localparam logic [3:0] F_BLT  = 4'd11;
    localparam logic [3:0] F_BGE  = 4'd12;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_MUL_LAT   = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_MAC_LAT   = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_LOAD_LAT  = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_BR_COST   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_PROG_LEN  = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_CYC_LIMIT = 3'd5;

    typedef struct packed {
        logic [CYC_W-1:0] ready;
        logic [XLEN-1:0]  value;
    } rf_entry_t;

    typedef struct packed {
        logic [PC_W-1:0]   next_pc;
        logic [OCYC_W-1:0] issue_cycle;
        logic [OCYC_W-1:0] cycle_after;
        logic              branch_taken;
        logic              write_enable;
        logic [REG_W-1:0]  write_reg;
        logic [XLEN-1:0]   write_value;
        logic              halted;
        logic              fault;
        logic              overrun;
    } res_t;

    function automatic logic [OCYC_W-1:0] sat20(input logic [CYC_W-1:0] v);
        return (v[CYC_W-1:OCYC_W] != '0) ? {OCYC_W{1'b1}} : v[OCYC_W-1:0];
    endfunction

    function automatic logic [LAT_W-1:0] at_least_one(input logic [LAT_W-1:0] v);
        return (v == '0) ? LAT_W'(1) : v;
    endfunction

endpackage

// ----- design/scoreboard_issue_execute_core.sv -----
// Scoreboard issue/execute core: one decoded instruction in, one result out.
// Depends on sie_pkg, sie_regfile, sie_dmem and sie_mul.
//
// Input channel (in_valid/in_stall) carries one decoded instruction per transfer;
// output channel (out_valid/out_stall) returns one result per instruction, in order.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data), used idle.
//
// An accepted instruction reads its sources from the register file on the accept
// edge and executes in the following cycle; its result is then registered onto the
// output. Add, sub, addi, store, branch, nop and halt finish in the execute state,
// back to back, with a one-cycle forward of the last register write. A load adds
// the load state (data memory read port). Mul and mac wait in the multiply state
// for the iterative multiplier, which does one 32x32 partial product a cycle.
// After reset a zero-fill sweep of all 4096 data memory words holds in_stall
// high; configuration writes are taken during the sweep.
// A stalled output keeps its result in the output register; one more finished
// result is held inside, and then in_stall stays high until the output drains.
module scoreboard_issue_execute_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [3:0]                       func,
    input  logic [sie_pkg::REG_W-1:0]        dest_reg,
    input  logic [sie_pkg::REG_W-1:0]        src1_reg,
    input  logic [sie_pkg::REG_W-1:0]        src2_reg,
    input  logic signed [sie_pkg::XLEN-1:0]  immediate,
    input  logic [sie_pkg::TGT_W-1:0]        branch_target,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [sie_pkg::PC_W-1:0]         next_pc,
    output logic [sie_pkg::OCYC_W-1:0]       issue_cycle,
    output logic [sie_pkg::OCYC_W-1:0]       cycle_after,
    output logic                             branch_taken,
    output logic                             write_enable,
    output logic [sie_pkg::REG_W-1:0]        write_reg,
    output logic signed [sie_pkg::XLEN-1:0]  write_value,
    output logic                             halted,
    output logic                             fault,
    output logic                             overrun,
    input  logic                             cfg_write,
    input  logic [sie_pkg::CFG_IW-1:0]       cfg_index,
    input  logic [sie_pkg::CFG_W-1:0]        cfg_data
);
    import sie_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;

    logic [LAT_W-1:0]  mul_lat_reg;
    logic [LAT_W-1:0]  mac_lat_reg;
    logic [LAT_W-1:0]  load_lat_reg;
    logic [LAT_W-1:0]  br_cost_reg;
    logic [PC_W-1:0]   prog_len_reg;
    logic [OCYC_W-1:0] cyc_limit_reg;

    logic [CYC_W-1:0]  cycle_reg;
    logic [CYC_W-1:0]  cycle_next;
    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic              stopped_reg;
    logic              stopped_next;

    logic [3:0]        ex_func_reg;
    logic [REG_W-1:0]  ex_rd_reg;
    logic [REG_W-1:0]  ex_rs1_reg;
    logic [REG_W-1:0]  ex_rs2_reg;
    logic [XLEN-1:0]   ex_imm_reg;
    logic [TGT_W-1:0]  ex_tgt_reg;

    logic [CYC_W-1:0]  issue_reg;
    logic              mac_cap_reg;
    logic [XLEN-1:0]   mac_val_reg;
    logic [CYC_W-1:0]  mac_rdy_reg;

    logic              fwd_valid_reg;
    logic [REG_W-1:0]  fwd_addr_reg;
    rf_entry_t         fwd_data_reg;

    logic              out_valid_reg;
    res_t              out_res_reg;
    res_t              hold_res_reg;

    // storage ports
    logic [REG_W-1:0]  rf_raddr1;
    rf_entry_t         rf_rdata1;
    rf_entry_t         rf_rdata2;
    logic              rf_we;
    rf_entry_t         rf_wdata;
    logic              dm_re;
    logic              dm_we;
    logic [XLEN-1:0]   dm_rdata;
    logic              dm_busy;
    logic              mul_start;
    logic              mul_done;
    logic [XLEN-1:0]   mul_product;

    // execute decode
    logic [3:0]        ex_f;
    logic              use1;
    logic              use2;
    logic              mac_f;
    rf_entry_t         src1_e;
    rf_entry_t         src2_e;
    logic [XLEN-1:0]   op_a;
    logic [XLEN-1:0]   op_b;
    logic [CYC_W-1:0]  rdy_a;
    logic [CYC_W-1:0]  rdy_b;
    logic [CYC_W-1:0]  issue_ab;
    logic [CYC_W-1:0]  issue_e;
    logic [XLEN-1:0]   addr_e;
    logic              in_range;
    logic [PC_W-1:0]   prog_end;
    logic              stop_now;
    logic [XLEN-1:0]   alu_e;
    logic              taken_e;
    logic [CYC_W-1:0]  issue_m;
    logic [XLEN-1:0]   val_m;

    // retire
    logic              fin;
    logic              goto_load;
    logic              goto_mul;
    logic              do_ret;
    logic [CYC_W-1:0]  r_issue;
    logic [XLEN-1:0]   r_val;
    logic [LAT_W-1:0]  r_lat;
    logic              r_wen;
    logic              r_taken;
    logic [CYC_W-1:0]  cyc_ret;
    logic [PC_W-1:0]   pc_ret;
    logic              ovr;
    logic              hlt;
    res_t              res_c;

    logic              out_free;
    logic              out_load;
    logic              accept_ok;
    logic              in_accept;

    assign out_free  = !out_valid_reg || !out_stall;
    assign accept_ok = (state_reg == ST_IDLE)
                       || ((fin || state_reg == ST_HOLD) && out_free);
    assign in_stall  = !accept_ok;
    assign in_accept = in_valid && accept_ok;
    assign out_load  = (fin || state_reg == ST_HOLD) && out_free;

    // ---------------------------------------------------------------- storage
    assign rf_raddr1 = (mul_start && mac_f) ? ex_rd_reg : src1_reg;

    sie_regfile u_regfile (
        .clk    (clk),
        .rst_n  (rst_n),
        .raddr1 (rf_raddr1),
        .raddr2 (src2_reg),
        .we     (rf_we),
        .waddr  (ex_rd_reg),
        .wdata  (rf_wdata),
        .rdata1 (rf_rdata1),
        .rdata2 (rf_rdata2)
    );

    sie_dmem u_dmem (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (dm_re),
        .raddr (addr_e[MEM_AW-1:0]),
        .we    (dm_we),
        .waddr (addr_e[MEM_AW-1:0]),
        .wdata (op_b),
        .rdata (dm_rdata),
        .busy  (dm_busy)
    );

    sie_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (op_a),
        .b       (op_b),
        .done    (mul_done),
        .product (mul_product)
    );

    // ---------------------------------------------------------------- decode
    assign ex_f  = (ex_func_reg > F_BGE) ? F_NOP : ex_func_reg;
    assign use1  = (ex_f != F_NOP);
    assign use2  = ex_f inside {[F_ADD:F_MAC], F_ST, [F_BEQ:F_BGE]};
    assign mac_f = (ex_f == F_MAC);

    // the write retired on the accept edge is not yet visible in the read data
    assign src1_e = (fwd_valid_reg && fwd_addr_reg == ex_rs1_reg) ? fwd_data_reg : rf_rdata1;
    assign src2_e = (fwd_valid_reg && fwd_addr_reg == ex_rs2_reg) ? fwd_data_reg : rf_rdata2;

    assign op_a  = use1 ? src1_e.value : '0;
    assign op_b  = use2 ? src2_e.value : '0;
    assign rdy_a = use1 ? src1_e.ready : '0;
    assign rdy_b = use2 ? src2_e.ready : '0;

    assign issue_ab = (rdy_a > rdy_b) ? rdy_a : rdy_b;
    assign issue_e  = (issue_ab > cycle_reg) ? issue_ab : cycle_reg;

    assign addr_e   = op_a + ex_imm_reg;
    assign in_range = (addr_e < XLEN'(MEM_WORDS));
    assign prog_end = (prog_len_reg < PC_W'(PROG_DEPTH)) ? prog_len_reg : PC_W'(PROG_DEPTH);
    assign stop_now = stopped_reg || (pc_reg >= prog_end);

    always_comb
    begin
        case (ex_f)
            F_ADD:   alu_e = op_a + op_b;
            F_SUB:   alu_e = op_a - op_b;
            F_ADDI:  alu_e = op_a + ex_imm_reg;
            default: alu_e = '0;
        endcase
    end

    always_comb
    begin
        case (ex_f)
            F_BEQ:   taken_e = (op_a == op_b);
            F_BNE:   taken_e = (op_a != op_b);
            F_BLT:   taken_e = ($signed(op_a) < $signed(op_b));
            F_BGE:   taken_e = ($signed(op_a) >= $signed(op_b));
            default: taken_e = 1'b0;
        endcase
    end

    assign issue_m = (mac_f && mac_rdy_reg > issue_reg) ? mac_rdy_reg : issue_reg;
    assign val_m   = mul_product + (mac_f ? mac_val_reg : '0);

    // ---------------------------------------------------------------- execute / retire
    always_comb
    begin
        fin          = 1'b0;
        goto_load    = 1'b0;
        goto_mul     = 1'b0;
        do_ret       = 1'b0;
        r_issue      = issue_e;
        r_val        = alu_e;
        r_lat        = LAT_W'(1);
        r_wen        = 1'b0;
        r_taken      = 1'b0;
        dm_re        = 1'b0;
        dm_we        = 1'b0;
        res_c        = '0;
        cycle_next   = cycle_reg;
        pc_next      = pc_reg;
        stopped_next = stopped_reg;
        cyc_ret      = '0;
        pc_ret       = '0;
        ovr          = 1'b0;
        hlt          = 1'b0;
        rf_we        = 1'b0;
        rf_wdata     = '0;

        case (state_reg)
            ST_EXEC:
            begin
                if (stop_now)
                begin
                    fin               = 1'b1;
                    stopped_next      = 1'b1;
                    res_c.next_pc     = pc_reg;
                    res_c.issue_cycle = sat20(cycle_reg);
                    res_c.cycle_after = sat20(cycle_reg);
                    res_c.halted      = 1'b1;
                end
                else if (ex_f == F_HALT)
                begin
                    fin               = 1'b1;
                    stopped_next      = 1'b1;
                    cycle_next        = cycle_reg + CYC_W'(1);
                    res_c.next_pc     = pc_reg;
                    res_c.issue_cycle = sat20(cycle_reg);
                    res_c.cycle_after = sat20(cycle_next);
                    res_c.halted      = 1'b1;
                end
                else if ((ex_f == F_LD || ex_f == F_ST) && !in_range)
                begin
                    fin               = 1'b1;
                    stopped_next      = 1'b1;
                    cycle_next        = issue_e;
                    res_c.next_pc     = pc_reg;
                    res_c.issue_cycle = sat20(issue_e);
                    res_c.cycle_after = sat20(issue_e);
                    res_c.halted      = 1'b1;
                    res_c.fault       = 1'b1;
                end
                else if (ex_f == F_LD)
                begin
                    goto_load = 1'b1;
                    dm_re     = 1'b1;
                end
                else if (ex_f == F_MUL || ex_f == F_MAC)
                begin
                    goto_mul = 1'b1;
                end
                else
                begin
                    fin     = 1'b1;
                    do_ret  = 1'b1;
                    r_wen   = (ex_f inside {F_ADD, F_SUB, F_ADDI}) && (ex_rd_reg != '0);
                    r_taken = taken_e;
                    dm_we   = (ex_f == F_ST);
                end
            end
            ST_LOAD:
            begin
                fin     = 1'b1;
                do_ret  = 1'b1;
                r_issue = issue_reg;
                r_val   = dm_rdata;
                r_lat   = at_least_one(load_lat_reg);
                r_wen   = (ex_rd_reg != '0);
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    fin     = 1'b1;
                    do_ret  = 1'b1;
                    r_issue = issue_m;
                    r_val   = val_m;
                    r_lat   = mac_f ? at_least_one(mac_lat_reg) : at_least_one(mul_lat_reg);
                    r_wen   = (ex_rd_reg != '0);
                end
            end
            default:
            begin
            end
        endcase

        if (do_ret)
        begin
            cyc_ret = r_taken ? r_issue + CYC_W'(at_least_one(br_cost_reg))
                              : r_issue + CYC_W'(1);
            pc_ret  = r_taken ? PC_W'(ex_tgt_reg) : pc_reg + PC_W'(1);
            ovr     = (cyc_ret > CYC_W'(cyc_limit_reg));
            hlt     = ovr || (pc_ret >= prog_end);

            rf_we          = r_wen;
            rf_wdata.ready = r_issue + CYC_W'(r_lat);
            rf_wdata.value = r_val;

            cycle_next   = cyc_ret;
            pc_next      = pc_ret;
            stopped_next = stopped_reg || hlt;

            res_c.next_pc      = pc_ret;
            res_c.issue_cycle  = sat20(r_issue);
            res_c.cycle_after  = sat20(cyc_ret);
            res_c.branch_taken = r_taken;
            res_c.write_enable = r_wen;
            res_c.write_reg    = r_wen ? ex_rd_reg : '0;
            res_c.write_value  = r_wen ? r_val : '0;
            res_c.halted       = hlt;
            res_c.overrun      = ovr;
        end
    end

    assign mul_start = goto_mul;

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (!dm_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC, ST_LOAD, ST_MUL:
            begin
                if (fin)
                begin
                    if (in_accept)
                    begin
                        state_next = ST_EXEC;
                    end
                    else if (out_free)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
                else if (goto_load)
                begin
                    state_next = ST_LOAD;
                end
                else if (goto_mul)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = in_accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mul_lat_reg   <= LAT_W'(5);
            mac_lat_reg   <= LAT_W'(6);
            load_lat_reg  <= LAT_W'(5);
            br_cost_reg   <= LAT_W'(3);
            prog_len_reg  <= PC_W'(8192);
            cyc_limit_reg <= OCYC_W'(1000000);
            cycle_reg     <= '0;
            pc_reg        <= '0;
            stopped_reg   <= 1'b0;
            mac_cap_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cycle_reg     <= cycle_next;
            pc_reg        <= pc_next;
            stopped_reg   <= stopped_next;
            mac_cap_reg   <= mul_start && mac_f;
            fwd_valid_reg <= rf_we;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_MUL_LAT:   mul_lat_reg   <= cfg_data[LAT_W-1:0];
                    CFG_MAC_LAT:   mac_lat_reg   <= cfg_data[LAT_W-1:0];
                    CFG_LOAD_LAT:  load_lat_reg  <= cfg_data[LAT_W-1:0];
                    CFG_BR_COST:   br_cost_reg   <= cfg_data[LAT_W-1:0];
                    CFG_PROG_LEN:  prog_len_reg  <= cfg_data[PC_W-1:0];
                    CFG_CYC_LIMIT: cyc_limit_reg <= cfg_data[OCYC_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ex_func_reg <= func;
            ex_rd_reg   <= dest_reg;
            ex_rs1_reg  <= src1_reg;
            ex_rs2_reg  <= src2_reg;
            ex_imm_reg  <= immediate;
            ex_tgt_reg  <= branch_target;
        end
        if (goto_load || goto_mul)
        begin
            issue_reg <= issue_e;
        end
        if (mac_cap_reg)
        begin
            mac_val_reg <= rf_rdata1.value;
            mac_rdy_reg <= rf_rdata1.ready;
        end
        fwd_addr_reg <= ex_rd_reg;
        fwd_data_reg <= rf_wdata;
        if (fin && !out_free)
        begin
            hold_res_reg <= res_c;
        end
        if (out_load)
        begin
            out_res_reg <= (state_reg == ST_HOLD) ? hold_res_reg : res_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign next_pc      = out_res_reg.next_pc;
    assign issue_cycle  = out_res_reg.issue_cycle;
    assign cycle_after  = out_res_reg.cycle_after;
    assign branch_taken = out_res_reg.branch_taken;
    assign write_enable = out_res_reg.write_enable;
    assign write_reg    = out_res_reg.write_reg;
    assign write_value  = out_res_reg.write_value;
    assign halted       = out_res_reg.halted;
    assign fault        = out_res_reg.fault;
    assign overrun      = out_res_reg.overrun;

    // ---------------------------------------------------------------- checks
    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_we |-> (ex_rd_reg != '0))
        else $error("register zero written");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_EXEC))
        else $error("accepted instruction did not reach execute");

    a_clear_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> in_stall)
        else $error("input taken during memory clear");

    a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("stopped core restarted");

    a_hold_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> out_valid_reg)
        else $error("held result with empty output register");

endmodule

// ----- design/sie_regfile.sv -----
// Architectural register file: value and ready cycle per register, two read ports.
// Depends on sie_pkg. Unwritten entries read as zero through per-entry valid bits.
module sie_regfile (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [sie_pkg::REG_W-1:0] raddr1,
    input  logic [sie_pkg::REG_W-1:0] raddr2,
    input  logic                    we,
    input  logic [sie_pkg::REG_W-1:0] waddr,
    input  sie_pkg::rf_entry_t      wdata,
    output sie_pkg::rf_entry_t      rdata1,
    output sie_pkg::rf_entry_t      rdata2
);
    import sie_pkg::*;

    rf_entry_t                rf_mem [NUM_REGISTERS];
    logic [NUM_REGISTERS-1:0] valid_reg;
    rf_entry_t                rdata1_reg;
    rf_entry_t                rdata2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    // read returns the old contents on a same-edge write; the core forwards
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            rf_mem[waddr] <= wdata;
        end
        rdata1_reg <= valid_reg[raddr1] ? rf_mem[raddr1] : '0;
        rdata2_reg <= valid_reg[raddr2] ? rf_mem[raddr2] : '0;
    end

    assign rdata1 = rdata1_reg;
    assign rdata2 = rdata2_reg;

endmodule

// ----- design/sie_dmem.sv -----
// Data memory, one read and one write port, with a zero-fill sweep after reset.
// Depends on sie_pkg for depth and word width.
module sie_dmem (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       re,
    input  logic [sie_pkg::MEM_AW-1:0] raddr,
    input  logic                       we,
    input  logic [sie_pkg::MEM_AW-1:0] waddr,
    input  logic [sie_pkg::XLEN-1:0]   wdata,
    output logic [sie_pkg::XLEN-1:0]   rdata,
    output logic                       busy
);
    import sie_pkg::*;

    logic [XLEN-1:0]   dm_mem [MEM_WORDS];
    logic [XLEN-1:0]   rdata_reg;
    logic [MEM_AW-1:0] clr_cnt_reg;
    logic              clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + MEM_AW'(1);
            if (clr_cnt_reg == MEM_AW'(MEM_WORDS - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            dm_mem[clr_cnt_reg] <= '0;
        end
        else if (we)
        begin
            dm_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= dm_mem[raddr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = clr_busy_reg;

endmodule

// ----- design/sie_mul.sv -----
// Iterative 64x64 multiplier keeping the low word: three 32x32 partial products.
// Depends on sie_pkg. start loads operands; done pulses once the product is complete.
module sie_mul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [sie_pkg::XLEN-1:0] a,
    input  logic [sie_pkg::XLEN-1:0] b,
    output logic                     done,
    output logic [sie_pkg::XLEN-1:0] product
);
    import sie_pkg::*;

    localparam int H = XLEN / 2;

    logic [1:0]      step_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [XLEN-1:0] a_reg;
    logic [XLEN-1:0] b_reg;
    logic [XLEN-1:0] prod_reg;
    logic [XLEN-1:0] acc_reg;
    logic [H-1:0]    op_x;
    logic [H-1:0]    op_y;
    logic [XLEN-1:0] pp;

    always_comb
    begin
        case (step_reg)
            2'd0:
            begin
                op_x = a_reg[H-1:0];
                op_y = b_reg[H-1:0];
            end
            2'd1:
            begin
                op_x = a_reg[H-1:0];
                op_y = b_reg[XLEN-1:H];
            end
            default:
            begin
                op_x = a_reg[XLEN-1:H];
                op_y = b_reg[H-1:0];
            end
        endcase
    end

    assign pp = op_x * op_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == 2'd3);
            if (busy_reg)
            begin
                step_reg <= step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // accumulate lags the product register by one step
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
        end
        else if (busy_reg)
        begin
            prod_reg <= pp;
            case (step_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg <= acc_reg + {prod_reg[H-1:0], {H{1'b0}}};
            endcase
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
